// ===== hdl/rrpci_pkg.sv =====
// Shared constants and types of the random reset and power-cycle injector.
package rrpci_pkg;

	// Field widths.
	localparam int SEED_W  = 31;
	localparam int DELAY_W = 14;
	localparam int HOLD_W  = 10;
	localparam int DRAW_W  = 14;
	localparam int MUL_W   = 18;
	localparam int CNT_W   = 5;

	// Generator step: seed = seed * LCG_MUL + LCG_ADD, modulo 2^31.
	localparam logic [MUL_W-1:0]  LCG_MUL  = 18'd214013;
	localparam logic [SEED_W-1:0] LCG_ADD  = 31'd2531011;
	localparam int                DRAW_LSB = 16;

	// Interval drawn for the next event is DELAY_BASE + draw mod DELAY_SPAN.
	localparam logic [DELAY_W-1:0] DELAY_BASE = 14'd5000;
	localparam logic [DELAY_W-1:0] DELAY_SPAN = 14'd5000;

	// Register values after reset.
	localparam logic [SEED_W-1:0]  SEED_RESET  = 31'd1;
	localparam logic [DELAY_W-1:0] FIRST_RESET = 14'd5000;
	localparam logic [HOLD_W-1:0]  HOLD_RESET  = 10'd500;

	// Configuration register indexes.
	localparam int              CFG_IDX_W   = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 2'd2;

	// One result item.
	typedef struct packed {
		logic               power_on;
		logic               reset_released;
		logic               frozen;
		logic               event_fired;
		logic               event_is_reset;
		logic [DELAY_W-1:0] next_delay;
	} res_t;

endpackage

// ===== hdl/rrpci_if.sv =====
// Handshake channels of the injector: tick requests, result requests and register writes.
interface rrpci_tick_if;
	logic valid;
	logic ready;
	logic fail_in;

	modport source (output valid, output fail_in, input ready);
	modport sink (input valid, input fail_in, output ready);
endinterface

interface rrpci_res_if;
	logic                         valid;
	logic                         ready;
	logic                         power_on;
	logic                         reset_released;
	logic                         frozen;
	logic                         event_fired;
	logic                         event_is_reset;
	logic [rrpci_pkg::DELAY_W-1:0] next_delay;

	modport source (output valid, output power_on, output reset_released, output frozen,
		output event_fired, output event_is_reset, output next_delay, input ready);
	modport sink (input valid, input power_on, input reset_released, input frozen,
		input event_fired, input event_is_reset, input next_delay, output ready);
endinterface

interface rrpci_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rrpci_pkg::CFG_IDX_W-1:0] index;
	logic [rrpci_pkg::SEED_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rrpci_lcg.sv =====
// Bit-serial generator step: one seed bit per cycle through a constant multiplier and adder.
module rrpci_lcg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rrpci_pkg::SEED_W-1:0] seed_in,
	output logic                         done,
	output logic [rrpci_pkg::SEED_W-1:0] seed_out
);

	localparam logic [rrpci_pkg::CNT_W-1:0] LAST = rrpci_pkg::CNT_W'(rrpci_pkg::SEED_W - 1);

	logic [rrpci_pkg::SEED_W-1:0] sh_q;
	logic [rrpci_pkg::SEED_W-1:0] res_q;
	logic [rrpci_pkg::MUL_W-1:0]  acc_q;
	logic                         carry_q;
	logic [rrpci_pkg::CNT_W-1:0]  cnt_q;
	logic                         busy_q;
	logic                         done_q;

	logic [rrpci_pkg::MUL_W:0] prod;
	logic [1:0]                bit_sum;

	// Partial product of the current seed bit, then the constant addend bit.
	always_comb begin
		prod = {1'b0, acc_q} + (sh_q[0] ? {1'b0, rrpci_pkg::LCG_MUL} : '0);
		bit_sum = {1'b0, prod[0]} + {1'b0, rrpci_pkg::LCG_ADD[cnt_q]} + {1'b0, carry_q};
	end

	// Control of the serial pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: result bits shift in from the top, LSB first.
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q    <= seed_in;
			acc_q   <= '0;
			carry_q <= 1'b0;
		end else if (busy_q) begin
			sh_q    <= sh_q >> 1;
			acc_q   <= prod[rrpci_pkg::MUL_W:1];
			carry_q <= bit_sum[1];
			res_q   <= {bit_sum[0], res_q[rrpci_pkg::SEED_W-1:1]};
		end
	end

	assign done     = done_q;
	assign seed_out = res_q;

endmodule

// ===== hdl/random_reset_power_cycle_injector_core.sv =====
// Top level of the random reset and power-cycle injector.
// Each tick request gives one result request. A tick on which no event starts is handled in the
// cycle it is taken. Its result is registered in the staging register and then in the output
// register, and the next tick can be taken once the staging register has been emptied. A tick
// that starts an event runs two generator steps through the bit-serial multiplier, then the
// compare-and-subtract steps of the interval reduction, and the finishing step. A finished result
// waits in a staging register and then in the output register, so one new tick is taken while a
// result is still unread.
// Register writes are taken at any time and are meant to come while the block is idle.
module random_reset_power_cycle_injector_core (
	input  logic        clk,
	input  logic        arst_n,
	rrpci_cfg_if.sink   cfg,
	rrpci_tick_if.sink  tick,
	rrpci_res_if.source result
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DRAW1 = 3'd1;
	localparam logic [2:0] ST_DRAW2 = 3'd2;
	localparam logic [2:0] ST_MOD   = 3'd3;

	logic [2:0]                      state_q;
	logic [rrpci_pkg::SEED_W-1:0]    seed_q;
	logic [rrpci_pkg::DELAY_W-1:0]   countdown_q;
	logic [rrpci_pkg::HOLD_W-1:0]    hold_ticks_q;
	logic [rrpci_pkg::HOLD_W-1:0]    hold_count_q;
	logic                            holding_q;
	logic                            hold_is_reset_q;
	logic [rrpci_pkg::DELAY_W-1:0]   pending_delay_q;
	logic                            stopped_q;
	logic [rrpci_pkg::DRAW_W-1:0]    rem_q;
	logic                            kind_q;
	logic                            res_pend_q;
	rrpci_pkg::res_t                 res_q;
	logic                            out_valid_q;
	rrpci_pkg::res_t                 out_q;

	logic                            accept;
	logic                            is_event;
	logic                            lcg_start;
	logic                            lcg_done;
	logic [rrpci_pkg::SEED_W-1:0]    lcg_seed_in;
	logic [rrpci_pkg::SEED_W-1:0]    lcg_seed_out;
	logic [rrpci_pkg::HOLD_W-1:0]    hold_dec;
	logic [rrpci_pkg::HOLD_W-1:0]    hold_first;
	logic [rrpci_pkg::DELAY_W-1:0]   new_delay;
	logic                            out_load;

	// Handshakes and event detection.
	assign accept    = tick.valid && tick.ready;
	assign tick.ready = (state_q == ST_IDLE) && !res_pend_q;
	assign cfg.ready  = 1'b1;
	assign is_event   = !stopped_q && !holding_q && !tick.fail_in && (countdown_q == '0);
	assign lcg_start  = (accept && is_event) || ((state_q == ST_DRAW1) && lcg_done);
	assign lcg_seed_in = (state_q == ST_DRAW1) ? lcg_seed_out : seed_q;
	assign out_load   = res_pend_q && (!out_valid_q || result.ready);

	// Hold counter arithmetic and the drawn interval.
	always_comb begin
		hold_dec   = (hold_count_q != '0) ? hold_count_q - 1'b1 : hold_count_q;
		hold_first = (hold_ticks_q == '0) ? '0 : hold_ticks_q - 1'b1;
		new_delay  = rrpci_pkg::DELAY_BASE + rem_q;
	end

	rrpci_lcg u_lcg (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (lcg_start),
		.seed_in  (lcg_seed_in),
		.done     (lcg_done),
		.seed_out (lcg_seed_out)
	);

	// Tick sequencer and injector state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			seed_q          <= rrpci_pkg::SEED_RESET;
			countdown_q     <= rrpci_pkg::FIRST_RESET;
			hold_ticks_q    <= rrpci_pkg::HOLD_RESET;
			hold_count_q    <= '0;
			holding_q       <= 1'b0;
			hold_is_reset_q <= 1'b0;
			pending_delay_q <= '0;
			stopped_q       <= 1'b0;
			res_pend_q      <= 1'b0;
		end else begin
			if (out_load) begin
				res_pend_q <= 1'b0;
			end

			// Register writes.
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					rrpci_pkg::CFG_SEED: begin
						seed_q <= cfg.data;
					end
					rrpci_pkg::CFG_FIRST: begin
						countdown_q <= cfg.data[rrpci_pkg::DELAY_W-1:0];
					end
					rrpci_pkg::CFG_HOLD: begin
						hold_ticks_q <= cfg.data[rrpci_pkg::HOLD_W-1:0];
					end
					default: begin
					end
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q <= '{power_on: 1'b1, reset_released: 1'b1, frozen: stopped_q,
							event_fired: 1'b0, event_is_reset: 1'b0, next_delay: '0};
						if (stopped_q) begin
							res_pend_q <= 1'b1;
						end else if (holding_q) begin
							res_q.power_on       <= hold_is_reset_q;
							res_q.reset_released <= !hold_is_reset_q;
							hold_count_q         <= hold_dec;
							if (hold_dec == '0) begin
								holding_q   <= 1'b0;
								countdown_q <= pending_delay_q;
							end
							res_pend_q <= 1'b1;
						end else if (tick.fail_in) begin
							stopped_q    <= 1'b1;
							res_q.frozen <= 1'b1;
							res_pend_q   <= 1'b1;
						end else if (is_event) begin
							state_q <= ST_DRAW1;
						end else begin
							countdown_q <= countdown_q - 1'b1;
							res_pend_q  <= 1'b1;
						end
					end
				end
				ST_DRAW1: begin
					if (lcg_done) begin
						rem_q   <= lcg_seed_out[rrpci_pkg::DRAW_LSB +: rrpci_pkg::DRAW_W];
						state_q <= ST_DRAW2;
					end
				end
				ST_DRAW2: begin
					if (lcg_done) begin
						seed_q  <= lcg_seed_out;
						kind_q  <= lcg_seed_out[rrpci_pkg::DRAW_LSB];
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					// Reduce the first draw one subtraction a cycle, then start the hold.
					if (rem_q >= rrpci_pkg::DELAY_SPAN) begin
						rem_q <= rem_q - rrpci_pkg::DELAY_SPAN;
					end else begin
						pending_delay_q <= new_delay;
						hold_is_reset_q <= kind_q;
						hold_count_q    <= hold_first;
						if (hold_first == '0) begin
							holding_q   <= 1'b0;
							countdown_q <= new_delay;
						end else begin
							holding_q <= 1'b1;
						end
						res_q <= '{power_on: kind_q, reset_released: !kind_q, frozen: 1'b0,
							event_fired: 1'b1, event_is_reset: kind_q, next_delay: new_delay};
						res_pend_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.power_on       = out_q.power_on;
	assign result.reset_released = out_q.reset_released;
	assign result.frozen         = out_q.frozen;
	assign result.event_fired    = out_q.event_fired;
	assign result.event_is_reset = out_q.event_is_reset;
	assign result.next_delay     = out_q.next_delay;

endmodule
